// ===== sv/repeating_decimal_cycle_finder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Repeating decimal cycle finder assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef REPEATING_DECIMAL_CYCLE_FINDER_TOP_MACROS_SVH
`define REPEATING_DECIMAL_CYCLE_FINDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property at every rising edge outside reset.
`define RDCF_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define RDCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RDCF_ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define RDCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/rdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Repeating decimal cycle finder package
// Shared widths, payload structs and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rdcf_pkg;

    localparam int MAX_DENOMINATOR_DEF = 4096;
    localparam int SHOWN_DIGITS_DEF    = 50;

    localparam int NUM_W   = 31;
    localparam int DEN_W   = 12;
    localparam int DIGIT_W = 4;
    localparam int POS_W   = 6;
    localparam int CLEN_W  = 12;

    typedef struct packed {
        logic [NUM_W-1:0] numerator;
        logic [DEN_W-1:0] denominator;
    } t_in;

    typedef struct packed {
        logic [NUM_W-1:0]   integer_part;
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   digit_position;
        logic               cycle_begins;
        logic               truncated;
        logic [CLEN_W-1:0]  cycle_length;
        logic               last;
        logic               div_error;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic clr_step;
        logic dig_step;
        logic look;
        logic zfin;
        logic emit;
        logic err;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_den;
        logic div_last;
        logic clr_last;
        logic rem_zero;
        logic rnew_zero;
        logic cnt_lim;
        logic hit;
        logic emit_last;
    } t_stat;

endpackage

// ===== sv/rdcf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rdcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Repeating decimal cycle finder controller
// Sequences integer division, table clearing, long division and digit output.
// ----------------------------------------------------------------------------
`include "repeating_decimal_cycle_finder_top_macros.svh"

module rdcf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rdcf_pkg::t_stat i_stat,
    output rdcf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import rdcf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_CLR  = 7'b0000100,
        S_STEP = 7'b0001000,
        S_LOOK = 7'b0010000,
        S_ZFIN = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.bad_den) begin
                        o_cmd.err = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = i_stat.rem_zero ? S_ZFIN : S_STEP;
                end
            end
            S_STEP: begin
                if (i_stat.cnt_lim) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.dig_step = 1'b1;
                    n_state = i_stat.rnew_zero ? S_ZFIN : S_LOOK;
                end
            end
            S_LOOK: begin
                // The table read for the new remainder lands in this cycle.
                o_cmd.look = 1'b1;
                n_state = i_stat.hit ? S_EMIT : S_STEP;
            end
            S_ZFIN: begin
                o_cmd.zfin = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `RDCF_ASSERT_HOLDS(a_look_after_step, i_clk, i_rst_n, (r_state == S_LOOK) |-> ($past(r_state) == S_STEP), "table check without a preceding digit step")
    `RDCF_ASSERT_HOLDS(a_idle_after_emit, i_clk, i_rst_n, ($fell(o_busy) && $past(i_rst_n)) |-> ($past(r_state) == S_EMIT), "run ended without emitting digits")

endmodule

// ===== sv/rdcf_dp.sv =====
// ----------------------------------------------------------------------------
// Repeating decimal cycle finder datapath
// Restoring divider, long-division digit unit, remainder table and digit buffer.
// ----------------------------------------------------------------------------
`include "repeating_decimal_cycle_finder_top_macros.svh"

module rdcf_dp #(
    parameter int MAX_DENOMINATOR = rdcf_pkg::MAX_DENOMINATOR_DEF,
    parameter int SHOWN_DIGITS    = rdcf_pkg::SHOWN_DIGITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rdcf_pkg::t_in   i_in,
    input  rdcf_pkg::t_cmd  i_cmd,
    output rdcf_pkg::t_stat o_stat,
    output rdcf_pkg::t_out  o_result,
    output logic            o_strobe
);
    import rdcf_pkg::*;

    localparam int AW    = $clog2(MAX_DENOMINATOR);
    localparam int CNT_W = $clog2(MAX_DENOMINATOR + 2);
    localparam int SW    = (SHOWN_DIGITS > 1) ? $clog2(SHOWN_DIGITS) : 1;
    localparam int EW    = $clog2(SHOWN_DIGITS + 1);
    localparam int CW    = (CNT_W > EW) ? CNT_W : EW;
    localparam int BIT_W = $clog2(NUM_W);
    localparam int R10_W = DEN_W + 4;

    // One decimal long-division step: digit in the upper bits, remainder below.
    function automatic logic [DIGIT_W+DEN_W-1:0] digit_step(
        input logic [DEN_W-1:0] rem,
        input logic [DEN_W-1:0] den
    );
        logic [R10_W-1:0]   t;
        logic [R10_W-1:0]   sub;
        logic [DIGIT_W-1:0] q;
        t = (R10_W'(rem) << 3) + (R10_W'(rem) << 1);
        q = '0;
        for (int b = 3; b >= 0; b--) begin
            sub = R10_W'(den) << b;
            if (t >= sub) begin
                t    = t - sub;
                q[b] = 1'b1;
            end
        end
        return {q, t[DEN_W-1:0]};
    endfunction

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [BIT_W-1:0] r_bit;
    logic [AW-1:0]    r_clr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_start;
    logic [EW-1:0]    r_emit;
    t_out             r_out;
    logic             r_ov;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_nx;

    logic [DIGIT_W-1:0] dig_q;
    logic [DEN_W-1:0]   dig_rnew;

    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    logic [CNT_W-1:0] tbl_wdata;
    logic [CNT_W-1:0] tbl_q;

    logic               buf_we;
    logic [DIGIT_W-1:0] buf_wdata;
    logic [DIGIT_W-1:0] buf_q;
    logic               cnt_in_buf;

    logic [CW-1:0]      pos_c;
    logic [CW-1:0]      shown;
    logic               trunc;
    logic [CNT_W:0]     clen_c;

    // Restoring division of the numerator, one quotient bit per cycle.
    always_comb begin
        trial  = {r_rem, r_num[NUM_W-1]};
        ge     = (trial >= {1'b0, r_den});
        rem_nx = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
    end

    assign {dig_q, dig_rnew} = digit_step(r_rem, r_den);

    assign cnt_in_buf = (CW'(r_cnt) < CW'(SHOWN_DIGITS));
    assign trunc      = (CW'(r_cnt) > CW'(SHOWN_DIGITS));
    assign shown      = trunc ? CW'(SHOWN_DIGITS) : CW'(r_cnt);
    assign pos_c      = CW'(r_emit) + CW'(1);
    assign clen_c     = (CNT_W+1)'(r_cnt) + (CNT_W+1)'(1) - (CNT_W+1)'(r_start);

    // During the clearing pass the initial remainder is marked as seen at once.
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = AW'(r_rem);
        tbl_wdata = r_cnt + CNT_W'(1);
        if (i_cmd.clr_step) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr;
            tbl_wdata = (r_clr == AW'(r_rem)) ? CNT_W'(1) : '0;
        end else if (i_cmd.look && !o_stat.hit) begin
            tbl_we = 1'b1;
        end
    end

    assign buf_we    = (i_cmd.dig_step || i_cmd.zfin) && cnt_in_buf;
    assign buf_wdata = i_cmd.zfin ? '0 : dig_q;

    rdcf_ram #(
        .WIDTH(CNT_W),
        .DEPTH(MAX_DENOMINATOR)
    ) u_seen_tbl (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(tbl_wdata),
        .i_raddr(AW'(dig_rnew)),
        .o_rdata(tbl_q)
    );

    rdcf_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(SHOWN_DIGITS)
    ) u_digit_buf (
        .i_clk  (i_clk),
        .i_we   (buf_we),
        .i_waddr(SW'(r_cnt)),
        .i_wdata(buf_wdata),
        .i_raddr(SW'(r_emit)),
        .o_rdata(buf_q)
    );

    always_comb begin
        o_stat           = '0;
        o_stat.bad_den   = (i_in.denominator == '0) ||
                           ({20'd0, i_in.denominator} >= 32'(MAX_DENOMINATOR));
        o_stat.div_last  = (r_bit == BIT_W'(NUM_W - 1));
        o_stat.clr_last  = (r_clr == AW'(MAX_DENOMINATOR - 1));
        o_stat.rem_zero  = (r_rem == '0);
        o_stat.rnew_zero = (dig_rnew == '0);
        o_stat.cnt_lim   = (CW'(r_cnt) >= CW'(MAX_DENOMINATOR));
        o_stat.hit       = (tbl_q != '0);
        o_stat.emit_last = (pos_c == shown);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= i_in.numerator;
            r_den   <= i_in.denominator;
            r_rem   <= '0;
            r_quo   <= '0;
            r_bit   <= '0;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_start <= CNT_W'(1);
            r_emit  <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= rem_nx;
            r_bit <= r_bit + BIT_W'(1);
        end
        if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
        if (i_cmd.dig_step) begin
            r_rem <= dig_rnew;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.look && o_stat.hit) begin
            r_start <= tbl_q;
        end
        if (i_cmd.zfin) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_start <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_emit                <= r_emit + EW'(1);
            r_out.integer_part    <= r_quo;
            r_out.digit           <= '0;
            r_out.digit_position  <= POS_W'(pos_c);
            r_out.cycle_begins    <= (pos_c == CW'(r_start));
            r_out.truncated       <= trunc;
            r_out.cycle_length    <= CLEN_W'(clen_c);
            r_out.last            <= o_stat.emit_last;
            r_out.div_error       <= 1'b0;
        end else if (i_cmd.err) begin
            r_out.integer_part    <= '0;
            r_out.digit           <= '0;
            r_out.digit_position  <= '0;
            r_out.cycle_begins    <= 1'b0;
            r_out.truncated       <= 1'b0;
            r_out.cycle_length    <= '0;
            r_out.last            <= 1'b0;
            r_out.div_error       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= i_cmd.emit || i_cmd.err;
        end
    end

    // The digit comes straight from the buffer's read register.
    always_comb begin
        o_result = r_out;
        if (!r_out.div_error) begin
            o_result.digit = buf_q;
        end
    end

    assign o_strobe = r_ov;

    `RDCF_ASSERT_NEXT(a_rem_below_den, i_clk, i_rst_n, i_cmd.dig_step, r_rem < r_den, "remainder not below divisor after a digit step")
    `RDCF_ASSERT_NEXT(a_last_emitted, i_clk, i_rst_n, i_cmd.emit && o_stat.emit_last, r_ov && r_out.last, "final digit not marked last")
    `RDCF_ASSERT_NEXT(a_err_result, i_clk, i_rst_n, i_cmd.err, r_ov && r_out.div_error && !r_out.last, "error transaction not delivered")

endmodule

// ===== sv/repeating_decimal_cycle_finder_top.sv =====
// ----------------------------------------------------------------------------
// Repeating decimal cycle finder
// Finds the repeating cycle of numerator/denominator by decimal long division.
// ----------------------------------------------------------------------------
// Usage: drive i_in and raise start; the transaction is taken on an edge where
// busy is low. A zero denominator, or one of MAX_DENOMINATOR or more, gives one
// error result on the next cycle and busy stays low. Otherwise busy stays high
// for the whole run, which goes through, in order:
//   integer division of all 31 numerator bits (one quotient bit per cycle),
//   clearing all MAX_DENOMINATOR remainder table entries (one entry per cycle),
//   long-division steps, each a digit step, then a table lookup whose read
//   data is registered, or a zero finish when the remainder becomes zero,
//   a zero finish instead when the integer quotient is exact,
//   then the shown digits, one per cycle, at most SHOWN_DIGITS.
// Each result is on o_result for one cycle with o_strobe high; the last one of
// a run has last set and comes in the first cycle after busy falls. The
// receiver cannot stall, so results are never held.
// Reset is synchronous, active low, and returns the block to idle; the table
// is cleared at the start of every run, so no pass follows reset.
// ----------------------------------------------------------------------------
module repeating_decimal_cycle_finder_top #(
    parameter int MAX_DENOMINATOR = rdcf_pkg::MAX_DENOMINATOR_DEF,
    parameter int SHOWN_DIGITS    = rdcf_pkg::SHOWN_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  rdcf_pkg::t_in  i_in,
    output logic           busy,
    output rdcf_pkg::t_out o_result,
    output logic           o_strobe
);
    import rdcf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rdcf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    rdcf_dp #(
        .MAX_DENOMINATOR(MAX_DENOMINATOR),
        .SHOWN_DIGITS   (SHOWN_DIGITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

endmodule
